// ===== hdl/dclm_pkg.sv =====
// ----------------------------------------------------------------------------
// dclm_pkg
// Shared widths, register codes, reset values and helpers for the
// dual-core load monitor.
// ----------------------------------------------------------------------------
`default_nettype none

package dclm_pkg;

  localparam int IMI_W    = 26;  // initial / calibrated maximum idle count
  localparam int CAL_W    = 10;  // calibration interval count
  localparam int MARGIN_W = 8;
  localparam int EVT_W    = 24;  // one event count of an interval report
  localparam int USAGE_W  = 7;
  localparam int IN_W     = 4 * EVT_W;
  localparam int OUT_W    = 16;  // 2 * USAGE_W padded to whole bytes
  localparam int USER_W   = 1;
  localparam int PCT_W    = IMI_W + 7;  // 100 * count fits here

  localparam int APB_AW   = 4;
  localparam int APB_DW   = 32;

  localparam int PCT_SCALE = 100;

  localparam logic [IMI_W-1:0]    IMI_RST     = IMI_W'(182750);
  localparam logic [CAL_W-1:0]    CAL_RST     = CAL_W'(45);
  localparam logic [MARGIN_W-1:0] MARGIN0_RST = MARGIN_W'(110);
  localparam logic [MARGIN_W-1:0] MARGIN1_RST = MARGIN_W'(100);
  localparam logic [IMI_W-1:0]    IMI_SAT     = '1;
  localparam logic [USAGE_W-1:0]  PCT_FULL    = USAGE_W'(PCT_SCALE);

  // register index codes, taken from paddr[3:2]
  localparam logic [1:0] REG_INIT_MAX   = 2'd0;
  localparam logic [1:0] REG_CAL_INT    = 2'd1;
  localparam logic [1:0] REG_MARGIN_C0  = 2'd2;
  localparam logic [1:0] REG_MARGIN_C1  = 2'd3;

  typedef struct packed {
    logic [EVT_W-1:0] run1;
    logic [EVT_W-1:0] idle1;
    logic [EVT_W-1:0] run0;
    logic [EVT_W-1:0] idle0;
  } report_t;

  // 100 * m as three shifted terms
  function automatic logic [PCT_W-1:0] pct_scale(input logic [IMI_W-1:0] m);
    logic [PCT_W-1:0] w;
    begin
      w = PCT_W'(m);
      pct_scale = (w << 6) + (w << 5) + (w << 2);
    end
  endfunction

endpackage

`default_nettype wire

// ===== hdl/dclm_ram.sv =====
// ----------------------------------------------------------------------------
// dclm_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module dclm_ram #(
  parameter int WIDTH = 52,
  parameter int DEPTH = 45
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hdl/dclm_sdiv.sv =====
// ----------------------------------------------------------------------------
// dclm_sdiv
// Bit-serial restoring divider: one quotient bit per cycle, NUM_W quotient bits.
// ----------------------------------------------------------------------------
`default_nettype none

module dclm_sdiv #(
  parameter int NUM_W = 40,
  parameter int DEN_W = 26
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] numer,
  input  logic [DEN_W-1:0] denom,
  output logic             busy,
  output logic [NUM_W-1:0] quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [NUM_W-1:0] sh;     // numerator bits out at the top, quotient bits in
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  assign trial = {rem, sh[NUM_W-1]};
  assign diff  = trial - {1'b0, den};
  assign ge    = (trial >= {1'b0, den});
  assign busy  = (cnt != '0);
  assign quot  = sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_W'(NUM_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh  <= numer;
      rem <= '0;
      den <= denom;
    end else if (busy) begin
      // remainder stays below den, so it fits DEN_W bits either way
      rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      sh  <= {sh[NUM_W-2:0], ge};
    end
  end

endmodule

`default_nettype wire

// ===== hdl/dual_core_load_monitor.sv =====
// ----------------------------------------------------------------------------
// dual_core_load_monitor
// Per-core load estimate from interval reports of idle and run counts.
// ----------------------------------------------------------------------------
// Each transfer on s_* is one interval report; it yields at most one transfer
// on m_* with the usage of both cores in percent and a calibrating flag.
// After reset the block calibrates: each report pushes idle+run of each core
// into a WINDOW-deep sample RAM and a running sum. The report that ends
// calibration sets the per-core maximum from the window average and the
// margin, and produces no output transfer.
// Steps: a sample update while calibrating, then the numerator set-up (the
// margin multiply for the report that ends calibration), the start of the two
// NUM_W-bit serial dividers (40 bits for the default window) that run in
// parallel, one quotient bit a cycle, and the output. One report is processed
// at a time; s_tready is high only while the sequencer is idle, so a new
// report is not taken before the last one has left the sequencer.
// A finished result waits in the output register; the next report is taken
// meanwhile and only its own result waits for m_tready.
// Reset loads the control and configuration registers with their defaults and seeds the window with
// initial_max_idle; a write of initial_max_idle before the first report
// reseeds it. No clearing pass: unwritten window entries read as the seed.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_core_load_monitor #(
  parameter int WINDOW = 45
) (
  input  logic                         clk,
  input  logic                         rst,
  // s_tdata: idle_count_core0, run_count_core0, idle_count_core1, run_count_core1
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [dclm_pkg::IN_W-1:0]    s_tdata,
  // m_tdata: usage_core0 [6:0], usage_core1 [13:7], zero padding
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [dclm_pkg::OUT_W-1:0]   m_tdata,
  // m_tuser: calibrating
  output logic [dclm_pkg::USER_W-1:0]  m_tuser,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dclm_pkg::APB_AW-1:0]  paddr,
  input  logic [dclm_pkg::APB_DW-1:0]  pwdata,
  output logic [dclm_pkg::APB_DW-1:0]  prdata,
  output logic                         pready
);

  import dclm_pkg::*;

  localparam int POS_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_W = IMI_W + $clog2(WINDOW + 1);
  localparam int NUM_W = SUM_W + MARGIN_W;

  localparam logic [SUM_W-1:0] SUM_RST = SUM_W'(WINDOW) * SUM_W'(IMI_RST);
  localparam logic [IMI_W-1:0] DIV_CAL = IMI_W'(WINDOW * PCT_SCALE);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(WINDOW - 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_UPD  = 3'd1;
  localparam logic [2:0] ST_PREP = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_WAIT = 3'd5;
  localparam logic [2:0] ST_OUT  = 3'd6;

  logic [2:0]          state;
  report_t             rpt;
  logic                item_cal;
  logic                cal_end;
  logic                cal_active;
  logic [CAL_W-1:0]    int_cnt;
  logic [POS_W-1:0]    write_pos;
  logic                wrapped;
  logic [IMI_W-1:0]    seed;
  logic [SUM_W-1:0]    sum0, sum1;
  logic [IMI_W-1:0]    max0, max1;
  logic [NUM_W-1:0]    num0, num1;

  logic [IMI_W-1:0]    init_max;
  logic [CAL_W-1:0]    cal_int;
  logic [MARGIN_W-1:0] margin0, margin1;

  logic [USAGE_W-1:0]  usage0, usage1;
  logic                out_cal;

  logic                cfg_wr;
  logic [1:0]          reg_idx;
  logic                ram_we;
  logic [2*IMI_W-1:0]  ram_rdata;
  logic [IMI_W-1:0]    old0, old1, smp0, smp1;
  logic [CAL_W-1:0]    cnt_inc, limit;
  logic                cal_done;
  logic [IMI_W-1:0]    m0, m1;
  logic                div_start;
  logic [IMI_W-1:0]    den0, den1;
  logic                div_busy0, div_busy1;
  logic [NUM_W-1:0]    quot0, quot1;
  logic [IMI_W-1:0]    cmax0, cmax1;
  logic                out_free;

  assign pready   = 1'b1;
  assign cfg_wr   = psel & penable & pwrite & pready;
  assign reg_idx  = paddr[3:2];
  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;

  // window entries past the write pointer still hold the seed until wrap
  assign old0 = wrapped ? ram_rdata[IMI_W-1:0] : seed;
  assign old1 = wrapped ? ram_rdata[2*IMI_W-1:IMI_W] : seed;
  assign smp0 = IMI_W'(rpt.idle0) + IMI_W'(rpt.run0);
  assign smp1 = IMI_W'(rpt.idle1) + IMI_W'(rpt.run1);
  assign ram_we = (state == ST_UPD);

  assign cnt_inc  = int_cnt + 1'b1;
  assign limit    = (cal_int == '0) ? CAL_W'(1) : cal_int;
  assign cal_done = (cnt_inc >= limit) || (cnt_inc == '0);

  assign m0 = (IMI_W'(rpt.idle0) < max0) ? IMI_W'(rpt.idle0) : max0;
  assign m1 = (IMI_W'(rpt.idle1) < max1) ? IMI_W'(rpt.idle1) : max1;

  assign div_start = (state == ST_DIV);
  assign den0 = cal_end ? DIV_CAL : max0;
  assign den1 = cal_end ? DIV_CAL : max1;

  always_comb begin
    if (|quot0[NUM_W-1:IMI_W]) begin
      cmax0 = IMI_SAT;
    end else if (quot0[IMI_W-1:0] == '0) begin
      cmax0 = IMI_W'(1);
    end else begin
      cmax0 = quot0[IMI_W-1:0];
    end
    if (|quot1[NUM_W-1:IMI_W]) begin
      cmax1 = IMI_SAT;
    end else if (quot1[IMI_W-1:0] == '0) begin
      cmax1 = IMI_W'(1);
    end else begin
      cmax1 = quot1[IMI_W-1:0];
    end
  end

  always_comb begin
    case (reg_idx)
      REG_INIT_MAX:  prdata = APB_DW'(init_max);
      REG_CAL_INT:   prdata = APB_DW'(cal_int);
      REG_MARGIN_C0: prdata = APB_DW'(margin0);
      REG_MARGIN_C1: prdata = APB_DW'(margin1);
      default:       prdata = '0;
    endcase
  end

  dclm_ram #(
    .WIDTH (2 * IMI_W),
    .DEPTH (WINDOW)
  ) u_window (
    .clk   (clk),
    .we    (ram_we),
    .waddr (write_pos),
    .wdata ({smp1, smp0}),
    .raddr (write_pos),
    .rdata (ram_rdata)
  );

  dclm_sdiv #(
    .NUM_W (NUM_W),
    .DEN_W (IMI_W)
  ) u_div0 (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .numer (num0),
    .denom (den0),
    .busy  (div_busy0),
    .quot  (quot0)
  );

  dclm_sdiv #(
    .NUM_W (NUM_W),
    .DEN_W (IMI_W)
  ) u_div1 (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .numer (num1),
    .denom (den1),
    .busy  (div_busy1),
    .quot  (quot1)
  );

  // sequencer and state of the estimator
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cal_active <= 1'b1;
      cal_end    <= 1'b0;
      int_cnt    <= '0;
      write_pos  <= '0;
      wrapped    <= 1'b0;
      seed       <= IMI_RST;
      sum0       <= SUM_RST;
      sum1       <= SUM_RST;
      max0       <= IMI_RST;
      max1       <= IMI_RST;
      init_max   <= IMI_RST;
      cal_int    <= CAL_RST;
      margin0    <= MARGIN0_RST;
      margin1    <= MARGIN1_RST;
    end else begin
      if (cfg_wr) begin
        case (reg_idx)
          REG_INIT_MAX: begin
            init_max <= pwdata[IMI_W-1:0];
            // reseed only before the first report
            if (cal_active && int_cnt == '0) begin
              seed      <= pwdata[IMI_W-1:0];
              sum0      <= SUM_W'(WINDOW) * SUM_W'(pwdata[IMI_W-1:0]);
              sum1      <= SUM_W'(WINDOW) * SUM_W'(pwdata[IMI_W-1:0]);
              max0      <= (pwdata[IMI_W-1:0] == '0) ? IMI_W'(1) : pwdata[IMI_W-1:0];
              max1      <= (pwdata[IMI_W-1:0] == '0) ? IMI_W'(1) : pwdata[IMI_W-1:0];
              write_pos <= '0;
              wrapped   <= 1'b0;
            end
          end
          REG_CAL_INT:   cal_int <= pwdata[CAL_W-1:0];
          REG_MARGIN_C0: margin0 <= pwdata[MARGIN_W-1:0];
          REG_MARGIN_C1: margin1 <= pwdata[MARGIN_W-1:0];
          default: ;
        endcase
      end

      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            cal_end <= 1'b0;
            state   <= cal_active ? ST_UPD : ST_PREP;
          end
        end
        ST_UPD: begin
          sum0    <= sum0 - SUM_W'(old0) + SUM_W'(smp0);
          sum1    <= sum1 - SUM_W'(old1) + SUM_W'(smp1);
          int_cnt <= cnt_inc;
          if (write_pos == POS_LAST) begin
            write_pos <= '0;
            wrapped   <= 1'b1;
          end else begin
            write_pos <= write_pos + 1'b1;
          end
          if (cal_done) begin
            cal_active <= 1'b0;
            cal_end    <= 1'b1;
            state      <= ST_MUL;
          end else begin
            state <= ST_PREP;
          end
        end
        ST_PREP: state <= ST_DIV;
        ST_MUL:  state <= ST_DIV;
        ST_DIV:  state <= ST_WAIT;
        ST_WAIT: begin
          if (!div_busy0) begin
            if (cal_end) begin
              max0  <= cmax0;
              max1  <= cmax1;
              state <= ST_IDLE;
            end else begin
              state <= ST_OUT;
            end
          end
        end
        ST_OUT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_tvalid) begin
      rpt      <= s_tdata;
      item_cal <= cal_active;
    end
    if (state == ST_PREP) begin
      // ceil(100*m/max) as floor((100*m + max - 1)/max)
      num0 <= NUM_W'(pct_scale(m0)) + NUM_W'(max0) - NUM_W'(1);
      num1 <= NUM_W'(pct_scale(m1)) + NUM_W'(max1) - NUM_W'(1);
    end else if (state == ST_MUL) begin
      num0 <= NUM_W'(sum0) * NUM_W'(margin0);
      num1 <= NUM_W'(sum1) * NUM_W'(margin1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      usage0  <= PCT_FULL - quot0[USAGE_W-1:0];
      usage1  <= PCT_FULL - quot1[USAGE_W-1:0];
      out_cal <= item_cal;
    end
  end

  assign m_tdata = {{(OUT_W - 2 * USAGE_W){1'b0}}, usage1, usage0};
  assign m_tuser = out_cal;

  // checks
  a_max_nonzero: assert property (@(posedge clk) disable iff (rst)
    (max0 != '0) && (max1 != '0))
    else $error("calibrated maximum is zero");

  a_cal_sticky: assert property (@(posedge clk) disable iff (rst)
    !cal_active |=> !cal_active)
    else $error("calibration restarted without reset");

  a_div_runs: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |=> (div_busy0 && div_busy1))
    else $error("dividers not running after start");

  a_usage_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT) |-> (quot0 <= NUM_W'(PCT_SCALE)) && (quot1 <= NUM_W'(PCT_SCALE)))
    else $error("usage quotient above full scale");

endmodule

`default_nettype wire

// ===== tb/tb_dual_core_load_monitor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dual_core_load_monitor
// Self-checking bench for the dual-core load monitor.
// ----------------------------------------------------------------------------
// Interval reports go in on the s_* stream and the usage results are checked
// on the m_* stream against a scoreboard that predicts calibration, the
// sliding sample window and the usage arithmetic of both cores. Registers are
// written over APB while the block is idle. One of three calibration setups
// is chosen per seed: a typical one, a zero-seeded one that ends on the first
// report, and one that drives the calibrated maxima to both limits.
// Both sides idle at random, with bursts, and the receiver holds off once for
// a long stretch so that the input stalls.
// ----------------------------------------------------------------------------

module tb_dual_core_load_monitor;
  import dclm_pkg::*;

  localparam int WINDOW_LEN     = 45;
  localparam int SETTLE_CYCLES  = 100;
  localparam int LONG_STALL     = 400;
  localparam int STALL_AT       = 700;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DIRECTED_LEN   = 20;

  typedef enum int {SCN_TYPICAL, SCN_ZERO_START, SCN_SATURATE} scenario_t;

  typedef struct {
    logic [USAGE_W-1:0] u0;
    logic [USAGE_W-1:0] u1;
    logic               cal;
  } usage_t;

  class usage_scoreboard;
    logic [IMI_W-1:0]    init_max;
    logic [CAL_W-1:0]    cal_len;
    logic [MARGIN_W-1:0] margin0;
    logic [MARGIN_W-1:0] margin1;
    logic [IMI_W-1:0]    win0[WINDOW_LEN];
    logic [IMI_W-1:0]    win1[WINDOW_LEN];
    longint unsigned     sum0;
    longint unsigned     sum1;
    logic [IMI_W-1:0]    max0;
    logic [IMI_W-1:0]    max1;
    logic [CAL_W-1:0]    reports_seen;
    bit                  calibrating;
    int                  slot;
    usage_t              pending_usage[$];
    int                  mismatches;
    int                  calib_results;
    int                  live_results;
    int                  silent_reports;

    function new();
      init_max     = IMI_RST;
      cal_len      = CAL_RST;
      margin0      = MARGIN0_RST;
      margin1      = MARGIN1_RST;
      reports_seen = '0;
      calibrating  = 1'b1;
      reseed();
    endfunction

    function void reseed();
      foreach (win0[i]) begin
        win0[i] = init_max;
        win1[i] = init_max;
      end
      sum0 = longint'(WINDOW_LEN) * init_max;
      sum1 = sum0;
      max0 = (init_max != 0) ? init_max : IMI_W'(1);
      max1 = max0;
      slot = 0;
    endfunction

    function void write_register(logic [1:0] idx, logic [APB_DW-1:0] value);
      case (idx)
        REG_INIT_MAX: begin
          init_max = value[IMI_W-1:0];
          // only reloads the window before the first report
          if (calibrating && reports_seen == 0) reseed();
        end
        REG_CAL_INT:   cal_len = value[CAL_W-1:0];
        REG_MARGIN_C0: margin0 = value[MARGIN_W-1:0];
        REG_MARGIN_C1: margin1 = value[MARGIN_W-1:0];
        default: ;
      endcase
    endfunction

    // 100 - ceil(100 * min(idle, peak) / peak)
    function logic [USAGE_W-1:0] load_percent(logic [EVT_W-1:0] idle, logic [IMI_W-1:0] peak);
      longint unsigned m;
      longint unsigned q;
      m = (longint'(idle) < longint'(peak)) ? longint'(idle) : longint'(peak);
      q = (longint'(PCT_SCALE) * m + longint'(peak) - 1) / longint'(peak);
      return USAGE_W'(longint'(PCT_SCALE) - q);
    endfunction

    function logic [IMI_W-1:0] calibrated_peak(longint unsigned total,
                                               logic [MARGIN_W-1:0] margin);
      longint unsigned v;
      v = total * longint'(margin) / longint'(WINDOW_LEN * PCT_SCALE);
      if (v > longint'(IMI_SAT)) v = longint'(IMI_SAT);
      if (v == 0) v = 1;
      return v[IMI_W-1:0];
    endfunction

    function void take_report(report_t r);
      logic [CAL_W-1:0] limit;
      logic [IMI_W-1:0] s0;
      logic [IMI_W-1:0] s1;
      int               p;
      bit               was_cal;
      usage_t           u;
      was_cal = calibrating;
      if (calibrating) begin
        limit = (cal_len != 0) ? cal_len : CAL_W'(1);
        p  = (slot < WINDOW_LEN) ? slot : 0;
        s0 = IMI_W'(r.idle0) + IMI_W'(r.run0);
        s1 = IMI_W'(r.idle1) + IMI_W'(r.run1);
        sum0 = sum0 - win0[p] + s0;
        sum1 = sum1 - win1[p] + s1;
        win0[p] = s0;
        win1[p] = s1;
        slot = (p + 1 >= WINDOW_LEN) ? 0 : p + 1;
        reports_seen = reports_seen + 1'b1;
        // last calibration report: set the maxima, no result
        if (reports_seen >= limit || reports_seen == 0) begin
          max0 = calibrated_peak(sum0, margin0);
          max1 = calibrated_peak(sum1, margin1);
          calibrating = 1'b0;
          silent_reports++;
          return;
        end
      end
      u.u0  = load_percent(r.idle0, max0);
      u.u1  = load_percent(r.idle1, max1);
      u.cal = was_cal;
      pending_usage.push_back(u);
    endfunction

    task flag_mismatch(string what);
      $display("[%0t] MISMATCH: %s", $realtime, what);
      mismatches++;
    endtask

    task check_usage(logic [USAGE_W-1:0] u0, logic [USAGE_W-1:0] u1, logic cal,
                     logic [1:0] pad);
      usage_t e;
      if (pending_usage.size() == 0) begin
        flag_mismatch($sformatf("result with nothing pending: u0=%0d u1=%0d cal=%0b",
                                u0, u1, cal));
        return;
      end
      e = pending_usage.pop_front();
      if (u0 !== e.u0) flag_mismatch($sformatf("usage_core0 %0d, want %0d", u0, e.u0));
      if (u1 !== e.u1) flag_mismatch($sformatf("usage_core1 %0d, want %0d", u1, e.u1));
      if (cal !== e.cal) flag_mismatch($sformatf("calibrating %0b, want %0b", cal, e.cal));
      if (pad !== 2'b00) flag_mismatch($sformatf("tdata padding %b", pad));
      if (e.cal) calib_results++;
      else live_results++;
    endtask
  endclass

  logic                 clk;
  logic                 rst      = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  // s_tdata: idle_count_core0, run_count_core0, idle_count_core1, run_count_core1
  logic [IN_W-1:0]      s_tdata  = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  // m_tdata: usage_core0, usage_core1, zero padding
  logic [OUT_W-1:0]     m_tdata;
  // m_tuser: calibrating
  logic [USER_W-1:0]    m_tuser;
  logic                 psel     = 1'b0;
  logic                 penable  = 1'b0;
  logic                 pwrite   = 1'b0;
  logic [APB_AW-1:0]    paddr    = '0;
  logic [APB_DW-1:0]    pwdata   = '0;
  logic [APB_DW-1:0]    prdata;
  logic                 pready;

  usage_scoreboard sb;
  scenario_t       scenario;
  int              sent;
  int              received;

  dual_core_load_monitor #(.WINDOW(WINDOW_LEN)) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [EVT_W-1:0] clamp_evt(longint v);
    return (v > longint'({EVT_W{1'b1}})) ? '1 : EVT_W'(v);
  endfunction

  function automatic logic [EVT_W-1:0] near_full();
    return EVT_W'($urandom_range(24'hF00000, 24'hFFFFFF));
  endfunction

  // idle counts clustered around the current maximum, with corner values
  function automatic logic [EVT_W-1:0] pick_idle(logic [IMI_W-1:0] peak);
    case ($urandom_range(0, 15))
      0: return '0;
      1: return '1;
      2: return clamp_evt(longint'(peak));
      3: return clamp_evt(longint'(peak) - 1);
      4: return clamp_evt(longint'(peak) + 1);
      5: return EVT_W'($urandom);
      6: return EVT_W'(1);
      default: return EVT_W'($urandom_range(0, 32'(clamp_evt(longint'(peak)))));
    endcase
  endfunction

  function automatic logic [EVT_W-1:0] pick_run();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return '1;
      2, 3: return EVT_W'($urandom);
      default: return EVT_W'($urandom_range(0, 2000));
    endcase
  endfunction

  function automatic report_t random_report();
    report_t r;
    bit      big;
    // the saturating setup needs a window of near-full samples
    big = (scenario == SCN_SATURATE) && sb.calibrating;
    r.idle0 = big ? near_full() : pick_idle(sb.max0);
    r.idle1 = big ? near_full() : pick_idle(sb.max1);
    r.run0  = big ? near_full() : pick_run();
    r.run1  = big ? near_full() : pick_run();
    return r;
  endfunction

  function automatic report_t directed_report(int k);
    report_t r;
    r = '0;
    case (k)
      0: r = '1;
      1: r = '0;
      2: begin
        r.idle0 = clamp_evt(longint'(sb.max0));
        r.idle1 = clamp_evt(longint'(sb.max1));
      end
      3: begin
        r.idle0 = clamp_evt(longint'(sb.max0) - 1);
        r.idle1 = clamp_evt(longint'(sb.max1) - 1);
      end
      4: begin
        r.idle0 = clamp_evt(longint'(sb.max0) + 1);
        r.idle1 = clamp_evt(longint'(sb.max1) + 1);
        r.run0  = '1;
      end
      5: begin
        r.idle0 = EVT_W'(1);
        r.idle1 = EVT_W'(1);
      end
      6: begin
        r.idle0 = 24'hAAAAAA;
        r.run0  = 24'h555555;
        r.idle1 = 24'h555555;
        r.run1  = 24'hAAAAAA;
      end
      7: begin
        r.idle0 = 24'h555555;
        r.run0  = 24'hAAAAAA;
        r.idle1 = 24'hAAAAAA;
        r.run1  = 24'h555555;
      end
      8: begin
        r.idle1 = '1;
        r.run1  = '1;
      end
      9: begin
        r.idle0 = '1;
        r.run0  = '1;
      end
      default: begin
        r.idle0 = pick_idle(sb.max0);
        r.idle1 = pick_idle(sb.max1);
        r.run0  = k[0] ? '1 : '0;
        r.run1  = k[0] ? '0 : '1;
      end
    endcase
    return r;
  endfunction

  // called at a falling edge; returns at a falling edge
  task automatic offer_reports(int n, bit directed);
    report_t r;
    int      gap;
    for (int k = 0; k < n; k++) begin
      r   = directed ? directed_report(k) : random_report();
      gap = ((sent / 60) % 4 == 3) ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      s_tvalid <= 1'b1;
      s_tdata  <= r;
      do @(posedge clk); while (!s_tready);
      sb.take_report(r);
      sent++;
      @(negedge clk);
    end
  endtask

  // wait for every pending result, then for any silent report still in flight
  task automatic settle();
    s_tvalid <= 1'b0;
    while (sb.pending_usage.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(logic [1:0] idx, logic [APB_DW-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_register(idx, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // result side: random hold-offs, bursts, and one long stall
  initial begin
    int gap;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (received == STALL_AT) gap = LONG_STALL;
      else if ((received / 50) % 4 == 1) gap = 0;
      else gap = $urandom_range(0, 18);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      sb.check_usage(m_tdata[USAGE_W-1:0], m_tdata[2*USAGE_W-1:USAGE_W], m_tuser[0],
                     m_tdata[OUT_W-1:2*USAGE_W]);
      received++;
      @(negedge clk);
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || psel || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no transfer for %0d cycles", quiet);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    sb       = new();
    sent     = 0;
    received = 0;
    scenario = scenario_t'($urandom_range(0, 2));
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // extremes first; each seed write reloads the window before the first report
    apb_write(REG_INIT_MAX, 32'hFFFF_FFFF);
    apb_write(REG_INIT_MAX, 32'h0);
    apb_write(REG_CAL_INT, 32'h0);
    apb_write(REG_CAL_INT, 32'd1023);
    apb_write(REG_MARGIN_C0, 32'd0);
    apb_write(REG_MARGIN_C1, 32'd255);
    case (scenario)
      SCN_TYPICAL: begin
        apb_write(REG_INIT_MAX, $urandom_range(1000, 200000));
        apb_write(REG_CAL_INT, $urandom_range(60, 300));
        apb_write(REG_MARGIN_C0, 32'd200);
        apb_write(REG_MARGIN_C1, 32'd50);
      end
      SCN_ZERO_START: begin
        apb_write(REG_INIT_MAX, 32'h0);
        apb_write(REG_CAL_INT, 32'h0);
        apb_write(REG_MARGIN_C0, $urandom_range(50, 200));
        apb_write(REG_MARGIN_C1, $urandom_range(50, 200));
      end
      default: begin
        apb_write(REG_INIT_MAX, 32'(IMI_SAT));
        apb_write(REG_CAL_INT, $urandom_range(70, 120));
        apb_write(REG_MARGIN_C0, 32'd255);
        apb_write(REG_MARGIN_C1, 32'd0);
      end
    endcase

    offer_reports(DIRECTED_LEN, 1'b1);
    settle();
    // seed write after the first report is stored but has no effect
    apb_write(REG_INIT_MAX, $urandom_range(0, 24'hFFFFFF));
    offer_reports(600, 1'b0);
    settle();
    apb_write(REG_INIT_MAX, $urandom);
    apb_write(REG_CAL_INT, 32'hFFFF_FFFF);
    apb_write(REG_MARGIN_C0, 32'd50);
    apb_write(REG_MARGIN_C1, 32'd200);
    offer_reports(400, 1'b0);
    settle();
    apb_write(REG_INIT_MAX, 32'd1);
    apb_write(REG_CAL_INT, 32'd1);
    apb_write(REG_MARGIN_C0, $urandom_range(50, 200));
    apb_write(REG_MARGIN_C1, $urandom_range(50, 200));
    offer_reports(330, 1'b0);
    settle();

    $display("Covered %0d reports (%s setup): %0d results while calibrating, %0d after,",
             sent, scenario.name(), sb.calib_results, sb.live_results);
    $display("%0d calibration end, maxima %0d / %0d, one %0d-cycle receiver stall",
             sb.silent_reports, sb.max0, sb.max1, LONG_STALL);
    if (sb.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== dual_core_load_monitor.f =====
hdl/dclm_pkg.sv
hdl/dclm_ram.sv
hdl/dclm_sdiv.sv
hdl/dual_core_load_monitor.sv
tb/tb_dual_core_load_monitor.sv
